// ===== sv/mnab_pkg.sv =====
// Package for the mesh node adjacency builder: op codes and controller states.
`timescale 1ns / 1ps
package mnab_pkg;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [8:0] {
		S_CLR   = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_SETUP = 9'b000000100,
		S_RDF   = 9'b000001000,
		S_FILL  = 9'b000010000,
		S_SCAN  = 9'b000100000,
		S_INS   = 9'b001000000,
		S_REMIT = 9'b010000000,
		S_STAT  = 9'b100000000
	} state_t;

	localparam int unsigned ID_W    = 13;
	localparam int unsigned LEN_W   = 5;
	localparam int unsigned TOT_W   = 17;
	localparam logic [TOT_W-1:0] TOTAL_MAX = '1;
	localparam logic [ID_W-1:0] NODE_COUNT_RST = 13'd4096;

endpackage

// ===== sv/mnab_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mnab_ram #(
	parameter int unsigned WIDTH = 13,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/mesh_node_adjacency_builder_core.sv =====
// Top level of the mesh node adjacency builder: controller, row fill RAM, adjacency RAM.
// Add without element end: the controller goes straight from idle to the status result.
// Element end: each ordered node pair is handled by a sequential scan of its row
//   through the adjacency RAM read port.
// Row read of n entries: one selection scan per output.
// Clear: sweeps every entry of the row fill RAM; reset runs the same sweep before
//   the first transfer is taken (configuration writes are taken throughout).
`timescale 1ns / 1ps
module mesh_node_adjacency_builder_core #(
	parameter int unsigned NUM_NODES      = 4096,
	parameter int unsigned ROW_CAP        = 16,
	parameter int unsigned MAX_ELEM_NODES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [12:0] node_id,
	input  logic        end_of_element,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [12:0] column_node,
	output logic [4:0]  row_length,
	output logic [16:0] nonzero_total,
	output logic        last,
	output logic        overflow,
	output logic        bad_node
);

	localparam int unsigned NW  = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
	localparam int unsigned AD  = NUM_NODES * ROW_CAP;
	localparam int unsigned AW  = (AD > 1) ? $clog2(AD) : 1;
	localparam int unsigned FW  = $clog2(ROW_CAP + 1);
	localparam int unsigned EW  = $clog2(MAX_ELEM_NODES + 1);
	localparam int unsigned EIW = (MAX_ELEM_NODES > 1) ? $clog2(MAX_ELEM_NODES) : 1;
	localparam int unsigned IW  = mnab_pkg::ID_W;

	mnab_pkg::state_t state_q;

	logic [IW-1:0]               node_count_q;
	logic [IW-1:0]               elem_q [MAX_ELEM_NODES];
	logic [EW-1:0]               elem_fill_q;
	logic [EIW-1:0]              j_q;
	logic [EIW-1:0]              k_q;
	logic [mnab_pkg::TOT_W-1:0]  total_q;
	logic                        ovf_q;
	logic                        bad_q;
	logic [NW-1:0]               clr_q;
	logic                        clr_stat_q;
	logic [NW-1:0]               row_q;
	logic [AW-1:0]               base_q;
	logic [FW-1:0]               n_q;
	logic [FW-1:0]               si_q;
	logic                        vld_s1;
	logic [FW-1:0]               idx_s1;
	logic                        found_q;
	logic                        is_read_q;
	logic                        diag_q;
	logic [IW-1:0]               id_q;
	logic [IW-1:0]               best_q;
	logic                        best_ok_q;
	logic [IW-1:0]               prev_q;
	logic                        prev_ok_q;
	logic [FW-1:0]               em_q;

	logic [IW-1:0] col_q;
	logic [4:0]    len_q;
	logic          last_q;
	logic          out_valid_q;

	logic [FW-1:0] fill_rdata;
	logic          fill_we;
	logic [NW-1:0] fill_waddr;
	logic [FW-1:0] fill_wdata;
	logic [IW-1:0] adj_rdata;
	logic          adj_we;
	logic [AW-1:0] adj_raddr;

	logic          accept;
	logic          id_ok;
	logic [EW-1:0] fill_new;
	logic          issue;
	logic          scan_done;
	logic          out_free;
	logic          ins_ok;
	logic [IW-1:0] p1;
	logic [IW-1:0] p2;
	logic          k_last;
	logic          j_last;
	logic          cand;

	assign in_stall  = (state_q != mnab_pkg::S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign id_ok     = (node_id != '0) && (node_id <= node_count_q)
		&& ({4'd0, node_id} <= 17'(NUM_NODES));
	assign out_free  = !out_valid_q || !out_stall;
	assign issue     = (state_q == mnab_pkg::S_SCAN) && (si_q < n_q);
	assign scan_done = vld_s1 && (idx_s1 == n_q - FW'(1));
	assign p1        = elem_q[j_q];
	assign p2        = elem_q[k_q];
	assign k_last    = (EW'(k_q) == elem_fill_q - EW'(1));
	assign j_last    = (EW'(j_q) == elem_fill_q - EW'(1));
	assign ins_ok    = (state_q == mnab_pkg::S_INS) && !found_q && (n_q < FW'(ROW_CAP));
	assign cand      = (adj_rdata != id_q) && (!prev_ok_q || adj_rdata > prev_q);

	always_comb begin
		if (elem_fill_q < EW'(MAX_ELEM_NODES) && id_ok) begin
			fill_new = elem_fill_q + EW'(1);
		end else begin
			fill_new = elem_fill_q;
		end
	end

	always_comb begin
		fill_we    = 1'b0;
		fill_waddr = row_q;
		fill_wdata = n_q + FW'(1);
		if (state_q == mnab_pkg::S_CLR) begin
			fill_we    = 1'b1;
			fill_waddr = clr_q;
			fill_wdata = '0;
		end else if (ins_ok) begin
			fill_we = 1'b1;
		end
	end

	assign adj_we    = ins_ok;
	assign adj_raddr = base_q + AW'(si_q);

	mnab_ram #(
		.WIDTH (FW),
		.DEPTH (NUM_NODES)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.raddr (row_q),
		.rdata (fill_rdata)
	);

	mnab_ram #(
		.WIDTH (IW),
		.DEPTH (AD)
	) u_adj_ram (
		.clk   (clk),
		.we    (adj_we),
		.waddr (base_q + AW'(n_q)),
		.wdata (p2),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= mnab_pkg::NODE_COUNT_RST;
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && op == mnab_pkg::OP_ADD && id_ok && elem_fill_q < EW'(MAX_ELEM_NODES)) begin
			elem_q[EIW'(elem_fill_q)] <= node_id;
		end
	end

	// scan pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= si_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mnab_pkg::S_CLR;
			clr_q       <= '0;
			clr_stat_q  <= 1'b0;
			elem_fill_q <= '0;
			j_q         <= '0;
			k_q         <= '0;
			total_q     <= '0;
			ovf_q       <= 1'b0;
			bad_q       <= 1'b0;
			row_q       <= '0;
			base_q      <= '0;
			n_q         <= '0;
			si_q        <= '0;
			found_q     <= 1'b0;
			is_read_q   <= 1'b0;
			diag_q      <= 1'b0;
			id_q        <= '0;
			best_q      <= '0;
			best_ok_q   <= 1'b0;
			prev_q      <= '0;
			prev_ok_q   <= 1'b0;
			em_q        <= '0;
			out_valid_q <= 1'b0;
			col_q       <= '0;
			len_q       <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				mnab_pkg::S_CLR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == NW'(NUM_NODES - 1)) begin
						state_q <= clr_stat_q ? mnab_pkg::S_STAT : mnab_pkg::S_IDLE;
					end
				end
				mnab_pkg::S_IDLE: begin
					if (accept) begin
						case (op)
							mnab_pkg::OP_ADD: begin
								if (!id_ok) begin
									bad_q <= 1'b1;
								end else if (elem_fill_q >= EW'(MAX_ELEM_NODES)) begin
									ovf_q <= 1'b1;
								end
								elem_fill_q <= fill_new;
								is_read_q   <= 1'b0;
								j_q         <= '0;
								k_q         <= '0;
								if (end_of_element && fill_new != '0) begin
									state_q <= mnab_pkg::S_SETUP;
								end else begin
									state_q <= mnab_pkg::S_STAT;
								end
							end
							mnab_pkg::OP_READ: begin
								if (!id_ok) begin
									bad_q   <= 1'b1;
									state_q <= mnab_pkg::S_STAT;
								end else begin
									row_q     <= NW'({4'd0, node_id} - 17'd1);
									id_q      <= node_id;
									is_read_q <= 1'b1;
									em_q      <= '0;
									prev_ok_q <= 1'b0;
									state_q   <= mnab_pkg::S_RDF;
								end
							end
							mnab_pkg::OP_CLEAR: begin
								total_q    <= '0;
								clr_q      <= '0;
								clr_stat_q <= 1'b1;
								state_q    <= mnab_pkg::S_CLR;
							end
							default: begin
								state_q <= mnab_pkg::S_IDLE;
							end
						endcase
					end
				end
				mnab_pkg::S_SETUP: begin
					row_q   <= NW'({4'd0, p1} - 17'd1);
					state_q <= mnab_pkg::S_RDF;
				end
				mnab_pkg::S_RDF: begin
					base_q  <= AW'(AW'(row_q) * AW'(ROW_CAP));
					state_q <= mnab_pkg::S_FILL;
				end
				mnab_pkg::S_FILL: begin
					n_q       <= fill_rdata;
					si_q      <= '0;
					found_q   <= 1'b0;
					best_ok_q <= 1'b0;
					diag_q    <= 1'b1;
					if (fill_rdata == '0) begin
						state_q <= is_read_q ? mnab_pkg::S_STAT : mnab_pkg::S_INS;
					end else begin
						state_q <= mnab_pkg::S_SCAN;
					end
				end
				mnab_pkg::S_SCAN: begin
					if (issue) begin
						si_q <= si_q + FW'(1);
					end
					if (vld_s1) begin
						if (!is_read_q) begin
							if (adj_rdata == p2) begin
								found_q <= 1'b1;
							end
						end else if (diag_q) begin
							if (adj_rdata == id_q) begin
								found_q <= 1'b1;
							end
						end else if (cand && (!best_ok_q || adj_rdata < best_q)) begin
							best_q    <= adj_rdata;
							best_ok_q <= 1'b1;
						end
					end
					if (scan_done) begin
						state_q <= is_read_q ? mnab_pkg::S_REMIT : mnab_pkg::S_INS;
					end
				end
				mnab_pkg::S_INS: begin
					if (!found_q) begin
						if (n_q >= FW'(ROW_CAP)) begin
							ovf_q <= 1'b1;
						end else if (total_q != mnab_pkg::TOTAL_MAX) begin
							total_q <= total_q + 17'd1;
						end
					end
					if (k_last) begin
						k_q <= '0;
						if (j_last) begin
							elem_fill_q <= '0;
							state_q     <= mnab_pkg::S_STAT;
						end else begin
							j_q     <= j_q + EIW'(1);
							state_q <= mnab_pkg::S_SETUP;
						end
					end else begin
						k_q     <= k_q + EIW'(1);
						state_q <= mnab_pkg::S_SETUP;
					end
				end
				mnab_pkg::S_REMIT: begin
					if (diag_q && !found_q) begin
						diag_q    <= 1'b0;
						si_q      <= '0;
						best_ok_q <= 1'b0;
						state_q   <= mnab_pkg::S_SCAN;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						col_q       <= diag_q ? id_q : best_q;
						len_q       <= 5'(n_q);
						last_q      <= (em_q + FW'(1) == n_q);
						em_q        <= em_q + FW'(1);
						if (!diag_q) begin
							prev_q    <= best_q;
							prev_ok_q <= 1'b1;
						end
						diag_q    <= 1'b0;
						si_q      <= '0;
						best_ok_q <= 1'b0;
						if (em_q + FW'(1) == n_q) begin
							state_q <= mnab_pkg::S_IDLE;
						end else begin
							state_q <= mnab_pkg::S_SCAN;
						end
					end
				end
				mnab_pkg::S_STAT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						col_q       <= '0;
						len_q       <= '0;
						last_q      <= 1'b1;
						clr_stat_q  <= 1'b0;
						state_q     <= mnab_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= mnab_pkg::S_IDLE;
				end
			endcase
		end
	end

	// flags and total are sampled with each loaded result
	logic [mnab_pkg::TOT_W-1:0] tot_o_q;
	logic                       ovf_o_q;
	logic                       bad_o_q;

	always_ff @(posedge clk) begin
		if ((state_q == mnab_pkg::S_STAT || state_q == mnab_pkg::S_REMIT) && out_free) begin
			tot_o_q <= total_q;
			ovf_o_q <= ovf_q;
			bad_o_q <= bad_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign column_node   = col_q;
	assign row_length    = len_q;
	assign nonzero_total = tot_o_q;
	assign last          = last_q;
	assign overflow      = ovf_o_q;
	assign bad_node      = bad_o_q;

endmodule
